/* design/sss_pkg.sv */
// Package for the sample set statistics unit: request payload types and fixed widths.
// No dependencies; imported by every module of the block except sss_addsub.
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

    localparam int SAMPLE_W = 24;
    localparam int TOTAL_W  = 17;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] maximum;
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] average;
        logic        [SAMPLE_W-1:0] deviation;
        logic        [TOTAL_W-1:0]  sample_total;
        logic                       overflowed;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] maximum;
        logic signed [SAMPLE_W-1:0] minimum;
        logic                       overflowed;
    } t_extremes;

endpackage

`default_nettype wire

/* design/sample_set_statistics_unit.sv */
// Sample set statistics unit, top level. Depends on sss_pkg, sss_accum, sss_seq.
// Input channel (i_in_valid / o_in_stall / i_in_data): one signed Q15.8 sample per
// request, with a flag on the last sample of a set. Samples that are not last are
// taken one per cycle while the sequencer is idle; each updates the running maximum,
// minimum, sum and count, and a registered square enters the sum of squares in the
// cycle after. A last sample starts the finishing sequencer, which runs every step
// through one shared adder: magnitude, mean division, mean negation, n*n, sum*sum,
// n*sumsq, subtraction, variance division and root. o_in_stall stays high while the
// sequencer runs, then one result request appears on o_out_valid / o_out_data.
// The result sits in an output register; while i_out_stall holds it, samples of the
// next set are taken as usual, and a further result waits in the sequencer until the
// register frees. Samples past COUNT_MAX are dropped and set the overflow flag.
// Reset clears all running state and the output valid; the unit is idle after it.
`timescale 1ns / 1ps
`default_nettype none

module sample_set_statistics_unit #(
    parameter int COUNT_MAX = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sss_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sss_pkg::t_out_item o_out_data
);

    import sss_pkg::*;

    localparam int CW = $clog2(COUNT_MAX + 1);
    localparam int SW = SAMPLE_W + CW;
    localparam int QW = 2 * SAMPLE_W - 2 + CW;

    logic                 w_take;
    logic                 w_start;
    logic                 w_busy;
    logic                 w_clear;
    logic signed [SW-1:0] w_sum;
    logic        [QW-1:0] w_sumsq;
    logic        [CW-1:0] w_count;
    t_extremes            w_ext;

    assign w_take     = i_in_valid && !w_busy;
    assign w_start    = w_take && i_in_data.last;
    assign o_in_stall = w_busy;

    sss_accum #(
        .COUNT_MAX (COUNT_MAX)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (i_in_data),
        .i_clear (w_clear),
        .o_sum   (w_sum),
        .o_sumsq (w_sumsq),
        .o_count (w_count),
        .o_ext   (w_ext)
    );

    sss_seq #(
        .COUNT_MAX (COUNT_MAX)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sum   (w_sum),
        .i_sumsq (w_sumsq),
        .i_count (w_count),
        .i_ext   (w_ext),
        .i_stall (i_out_stall),
        .o_busy  (w_busy),
        .o_clear (w_clear),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* design/sss_addsub.sv */
// Shared adder/subtractor of the finishing sequencer; carry out doubles as unsigned a >= b.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module sss_addsub #(
    parameter int W = 80
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_res,
    output logic         o_carry
);

    logic [W-1:0] w_b;
    logic [W:0]   w_sum;

    assign w_b     = i_sub ? ~i_b : i_b;
    assign w_sum   = {1'b0, i_a} + {1'b0, w_b} + {{W{1'b0}}, i_sub};
    assign o_res   = w_sum[W-1:0];
    assign o_carry = w_sum[W];

endmodule

`default_nettype wire

/* design/sss_accum.sv */
// Running maximum, minimum, sum, sum of squares and saturating count of one sample set.
// Depends on sss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sss_accum #(
    parameter int COUNT_MAX = 65536,
    localparam int CW = $clog2(COUNT_MAX + 1),
    localparam int SW = sss_pkg::SAMPLE_W + CW,
    localparam int QW = 2 * sss_pkg::SAMPLE_W - 2 + CW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_take,
    input  sss_pkg::t_in_item        i_item,
    input  logic                     i_clear,
    output logic signed [SW-1:0]     o_sum,
    output logic        [QW-1:0]     o_sumsq,
    output logic        [CW-1:0]     o_count,
    output sss_pkg::t_extremes       o_ext
);

    import sss_pkg::*;

    localparam int PW = 2 * SAMPLE_W - 1;

    logic signed [SAMPLE_W-1:0]   r_max, n_max;
    logic signed [SAMPLE_W-1:0]   r_min, n_min;
    logic signed [SW-1:0]         r_sum, n_sum;
    logic        [QW-1:0]         r_sumsq, n_sumsq;
    logic        [CW-1:0]         r_count, n_count;
    logic                         r_ovf, n_ovf;
    logic        [PW-1:0]         r_sqr, n_sqr;
    logic                         r_sqv, n_sqv;

    logic signed [2*SAMPLE_W-1:0] w_square;
    logic                         w_full;
    logic                         w_counted;
    logic signed [SAMPLE_W-1:0]   w_x;

    assign w_x       = i_item.sample;
    assign w_square  = w_x * w_x;
    assign w_full    = (r_count == CW'(COUNT_MAX));
    assign w_counted = i_take && !w_full;

    always_comb begin
        n_max   = r_max;
        n_min   = r_min;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_sqr   = w_square[PW-1:0];
        n_sqv   = w_counted;
        if (r_sqv) begin
            n_sumsq = r_sumsq + {{(QW-PW){1'b0}}, r_sqr};
        end
        if (i_take && w_full) begin
            n_ovf = 1'b1;
        end
        if (w_counted) begin
            if (r_count == '0) begin
                n_max = w_x;
                n_min = w_x;
            end else begin
                if (w_x > r_max) begin
                    n_max = w_x;
                end
                if (w_x < r_min) begin
                    n_min = w_x;
                end
            end
            n_sum   = r_sum + {{CW{w_x[SAMPLE_W-1]}}, w_x};
            n_count = r_count + 1'b1;
        end
        if (i_clear) begin
            n_max   = '0;
            n_min   = '0;
            n_sum   = '0;
            n_sumsq = '0;
            n_count = '0;
            n_ovf   = 1'b0;
            n_sqv   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= '0;
            r_min   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sqv   <= 1'b0;
        end else begin
            r_max   <= n_max;
            r_min   <= n_min;
            r_sum   <= n_sum;
            r_sumsq <= n_sumsq;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_sqv   <= n_sqv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqr <= n_sqr;
    end

    assign o_sum            = r_sum;
    assign o_sumsq          = r_sumsq;
    assign o_count          = r_count;
    assign o_ext.maximum    = r_max;
    assign o_ext.minimum    = r_min;
    assign o_ext.overflowed = r_ovf;

endmodule

`default_nettype wire

/* design/sss_seq.sv */
// Finishing sequencer: mean, variance by exact integer division and bit-serial root,
// all through one shared adder. Holds the result request register. Depends on sss_pkg, sss_addsub.
`timescale 1ns / 1ps
`default_nettype none

module sss_seq #(
    parameter int COUNT_MAX = 65536,
    localparam int CW = $clog2(COUNT_MAX + 1),
    localparam int SW = sss_pkg::SAMPLE_W + CW,
    localparam int QW = 2 * sss_pkg::SAMPLE_W - 2 + CW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [SW-1:0] i_sum,
    input  logic        [QW-1:0] i_sumsq,
    input  logic        [CW-1:0] i_count,
    input  sss_pkg::t_extremes   i_ext,
    input  logic                 i_stall,
    output logic                 o_busy,
    output logic                 o_clear,
    output logic                 o_valid,
    output sss_pkg::t_out_item   o_data
);

    import sss_pkg::*;

    localparam int W    = 2 * SAMPLE_W - 2 + 2 * CW;
    localparam int CNTW = $clog2(W);
    localparam int NW   = 2 * CW;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MAG  = 4'd1;
    localparam logic [3:0] ST_DIVA = 4'd2;
    localparam logic [3:0] ST_NEGA = 4'd3;
    localparam logic [3:0] ST_MULN = 4'd4;
    localparam logic [3:0] ST_MULS = 4'd5;
    localparam logic [3:0] ST_MULQ = 4'd6;
    localparam logic [3:0] ST_SUBV = 4'd7;
    localparam logic [3:0] ST_DIVV = 4'd8;
    localparam logic [3:0] ST_ROOT = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    logic [3:0]          r_state, n_state;
    logic [W-1:0]        r_a, n_a;
    logic [W-1:0]        r_b, n_b;
    logic [W-1:0]        r_c, n_c;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic [SW-1:0]       r_mag, n_mag;
    logic                r_neg, n_neg;
    logic [NW-1:0]       r_nn, n_nn;
    logic [W-1:0]        r_ss, n_ss;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    t_out_item           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [W-1:0]        u_a;
    logic [W-1:0]        u_b;
    logic                u_sub;
    logic [W-1:0]        u_res;
    logic                u_carry;

    logic [W-1:0]        w_n_ext;
    logic [W-1:0]        w_n_top;
    logic [SW-1:0]       w_mag;
    logic                w_last_step;
    logic [CW+TOTAL_W-1:0] w_total;

    sss_addsub #(
        .W (W)
    ) u_addsub (
        .i_a     (u_a),
        .i_b     (u_b),
        .i_sub   (u_sub),
        .o_res   (u_res),
        .o_carry (u_carry)
    );

    assign w_n_ext     = {{(W-CW){1'b0}}, i_count};
    assign w_n_top     = {i_count, {(W-CW){1'b0}}};
    assign w_mag       = i_sum[SW-1] ? u_res[SW-1:0] : i_sum;
    assign w_last_step = (r_cnt == '0);
    assign w_total     = {{TOTAL_W{1'b0}}, i_count};

    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b1;
        case (r_state)
            ST_MAG: begin
                u_b = {{(W-SW){i_sum[SW-1]}}, i_sum};
            end
            ST_DIVA, ST_DIVV: begin
                u_a = {r_a[W-2:0], r_b[W-1]};
                u_b = r_c;
            end
            ST_NEGA: begin
                u_b = r_b;
            end
            ST_MULN, ST_MULS, ST_MULQ: begin
                u_a   = {r_a[W-2:0], 1'b0};
                u_b   = r_c;
                u_sub = 1'b0;
            end
            ST_SUBV: begin
                u_a = r_a;
                u_b = r_ss;
            end
            ST_ROOT: begin
                u_a = {r_a[W-3:0], r_b[W-1:W-2]};
                u_b = {r_c[W-3:0], 2'b01};
            end
            default: begin
                u_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_cnt       = r_cnt;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_nn        = r_nn;
        n_ss        = r_ss;
        n_avg       = r_avg;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        o_clear     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_MAG;
                end
            end
            ST_MAG: begin
                n_neg   = i_sum[SW-1];
                n_mag   = w_mag;
                n_a     = '0;
                n_b     = {w_mag, {(W-SW){1'b0}}};
                n_c     = w_n_ext;
                n_cnt   = CNTW'(SW - 1);
                n_state = ST_DIVA;
            end
            ST_DIVA, ST_DIVV: begin
                n_a   = u_carry ? u_res : u_a;
                n_b   = {r_b[W-2:0], u_carry};
                n_cnt = r_cnt - 1'b1;
                if (w_last_step) begin
                    if (r_state == ST_DIVA) begin
                        n_state = ST_NEGA;
                    end else begin
                        n_b     = {n_b[2*SAMPLE_W-1:0], {(W-2*SAMPLE_W){1'b0}}};
                        n_a     = '0;
                        n_c     = '0;
                        n_cnt   = CNTW'(SAMPLE_W - 1);
                        n_state = ST_ROOT;
                    end
                end
            end
            ST_NEGA: begin
                n_avg   = r_neg ? u_res[SAMPLE_W-1:0] : r_b[SAMPLE_W-1:0];
                n_a     = '0;
                n_b     = w_n_top;
                n_c     = w_n_ext;
                n_cnt   = CNTW'(CW - 1);
                n_state = ST_MULN;
            end
            ST_MULN, ST_MULS, ST_MULQ: begin
                n_a   = r_b[W-1] ? u_res : u_a;
                n_b   = {r_b[W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (w_last_step) begin
                    if (r_state == ST_MULN) begin
                        n_nn    = n_a[NW-1:0];
                        n_a     = '0;
                        n_b     = {r_mag, {(W-SW){1'b0}}};
                        n_c     = {{(W-SW){1'b0}}, r_mag};
                        n_cnt   = CNTW'(SW - 1);
                        n_state = ST_MULS;
                    end else if (r_state == ST_MULS) begin
                        n_ss    = n_a;
                        n_a     = '0;
                        n_b     = w_n_top;
                        n_c     = {{(W-QW){1'b0}}, i_sumsq};
                        n_cnt   = CNTW'(CW - 1);
                        n_state = ST_MULQ;
                    end else begin
                        n_state = ST_SUBV;
                    end
                end
            end
            ST_SUBV: begin
                n_b     = u_res;
                n_a     = '0;
                n_c     = {{(W-NW){1'b0}}, r_nn};
                n_cnt   = CNTW'(W - 1);
                n_state = ST_DIVV;
            end
            ST_ROOT: begin
                n_a   = u_carry ? u_res : u_a;
                n_b   = {r_b[W-3:0], 2'b00};
                n_c   = {r_c[W-2:0], u_carry};
                n_cnt = r_cnt - 1'b1;
                if (w_last_step) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.maximum      = i_ext.maximum;
                    n_out.minimum      = i_ext.minimum;
                    n_out.average      = r_avg;
                    n_out.deviation    = r_c[SAMPLE_W-1:0];
                    n_out.sample_total = w_total[TOTAL_W-1:0];
                    n_out.overflowed   = i_ext.overflowed;
                    n_out_valid        = 1'b1;
                    o_clear            = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_cnt <= n_cnt;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_nn  <= n_nn;
        r_ss  <= n_ss;
        r_avg <= n_avg;
        r_out <= n_out;
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

/* tb/sv/sample_set_statistics_unit_tb.sv */
// Self-checking bench for sample_set_statistics_unit: directed and random sets.
// It predicts max, min, mean, deviation, count and overflow flag per set and checks every result.
// Depends on sss_pkg and the sample_set_statistics_unit RTL.
`timescale 1ns / 1ps

module sample_set_statistics_unit_tb;

    import sss_pkg::*;

    localparam int SET_LIMIT  = 65536;
    localparam int RAND_ITEMS = 750;
    localparam int HOLD_LEN   = 1500;
    localparam int DRAIN_LEN  = 300;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_out_stall = 1'b0;
    t_in_item   i_in_data   = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;

    t_in_item   pending_samples[$];
    t_out_item  expected_stats[$];

    logic signed [SAMPLE_W-1:0] acc_max = '0;
    logic signed [SAMPLE_W-1:0] acc_min = '0;
    longint     acc_sum = 0;
    longint     acc_sq  = 0;
    int         acc_n   = 0;
    logic       acc_ovf = 1'b0;

    int         cycle_count  = 0;
    int         results_seen = 0;
    int         fail_count   = 0;
    int         hold_left    = 0;
    logic       hold_done    = 1'b0;
    logic       in_taken     = 1'b0;
    logic       calm;

    assign calm = (cycle_count >= 3000) && (cycle_count < 9000);

    sample_set_statistics_unit #(
        .COUNT_MAX(SET_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v) begin
                root = cand;
            end
        end
        return root;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(9))
            6, 7:    v = SAMPLE_W'(int'($urandom_range(2000)) - 1000);
            8:       v = S_MAX;
            9:       v = S_MIN;
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic add_item(input logic signed [SAMPLE_W-1:0] v, input logic is_last);
        t_in_item it;
        it.sample = v;
        it.last   = is_last;
        pending_samples.push_back(it);
    endtask

    task automatic absorb_sample(input t_in_item it);
        longint              sx;
        longint              avg;
        logic signed [127:0] n_w;
        logic signed [127:0] spread;
        logic [63:0]         root;
        t_out_item           r;
        sx = it.sample;
        if (acc_n >= SET_LIMIT) begin
            acc_ovf = 1'b1;
        end else begin
            if (acc_n == 0) begin
                acc_max = it.sample;
                acc_min = it.sample;
            end else begin
                if (it.sample > acc_max) acc_max = it.sample;
                if (it.sample < acc_min) acc_min = it.sample;
            end
            acc_sum += sx;
            acc_sq  += sx * sx;
            acc_n++;
        end
        if (it.last) begin
            n_w    = 128'(acc_n);
            spread = n_w * acc_sq - acc_sum * acc_sum;
            spread = spread / (n_w * n_w);
            if (spread < 0) spread = 0;
            root = floor_root(spread[63:0]);
            avg  = acc_sum / longint'(acc_n);
            r.maximum      = acc_max;
            r.minimum      = acc_min;
            r.average      = avg[SAMPLE_W-1:0];
            r.deviation    = root[SAMPLE_W-1:0];
            r.sample_total = acc_n[TOTAL_W-1:0];
            r.overflowed   = acc_ovf;
            expected_stats.push_back(r);
            acc_max = '0;
            acc_min = '0;
            acc_sum = 0;
            acc_sq  = 0;
            acc_n   = 0;
            acc_ovf = 1'b0;
        end
    endtask

    task automatic note_field(input string fname, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("%0t: %s expected %0d, got %0d", $realtime, fname, want, got);
            end
        end
    endtask

    // accept requests and check results
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count++;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                absorb_sample(i_in_data);
                void'(pending_samples.pop_front());
                in_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_stats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with none expected, max %0d min %0d n %0d",
                                 $realtime, o_out_data.maximum, o_out_data.minimum,
                                 o_out_data.sample_total);
                    end
                end else begin
                    want = expected_stats.pop_front();
                    note_field("maximum", longint'(want.maximum),
                               longint'(o_out_data.maximum));
                    note_field("minimum", longint'(want.minimum),
                               longint'(o_out_data.minimum));
                    note_field("average", longint'(want.average),
                               longint'(o_out_data.average));
                    note_field("deviation", longint'(want.deviation),
                               longint'(o_out_data.deviation));
                    note_field("sample_total", longint'(want.sample_total),
                               longint'(o_out_data.sample_total));
                    note_field("overflowed", longint'(want.overflowed),
                               longint'(o_out_data.overflowed));
                    results_seen++;
                end
            end
        end
    end

    // sender: hold a stalled request, otherwise offer the next one or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            i_in_valid <= 1'b1;
        end else if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
            i_in_valid <= 1'b1;
            i_in_data  <= pending_samples[0];
        end else begin
            i_in_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // receiver: random stalls plus one long hold-off to back up the unit
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && results_seen >= 12) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 24);
        end
    end

    initial begin
        int len;
        int queued;
        add_item(S_MAX, 1'b1);
        add_item(S_MIN, 1'b1);
        add_item('0, 1'b1);
        add_item(S_MIN, 1'b0);
        add_item(S_MAX, 1'b1);
        add_item(S_MAX, 1'b0);
        add_item(S_MIN, 1'b1);
        add_item(-24'sd1, 1'b0);
        add_item(-24'sd2, 1'b1);
        add_item(24'sd1, 1'b0);
        add_item(24'sd2, 1'b1);
        for (int i = 0; i < 4; i++) add_item(S_MAX, i == 3);
        for (int i = 0; i < 3; i++) add_item(S_MIN, i == 2);

        queued = 0;
        while (queued < RAND_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) add_item(rand_sample(), i == len - 1);
            queued += len;
        end

        add_item(24'sd5, 1'b1);
        add_item(-24'sd3, 1'b0);
        add_item(24'sd4, 1'b1);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_samples.size() > 0) @(posedge i_clk);
        while (expected_stats.size() > 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);
        if (fail_count == 0 && expected_stats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(64'd20_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
